### rtl/bblru_pkg.sv
// ----------------------------------------------------------------------------
// bblru_pkg
// Shared types and constants of the byte-budget LRU chunk directory.
// ----------------------------------------------------------------------------
package bblru_pkg;

    localparam int ENTRIES   = 32;
    localparam int SLOT_W    = $clog2(ENTRIES);
    localparam int BYTES_W   = 48;
    localparam int ENTRY_B_W = 32;

    localparam logic [1:0] ST_HIT    = 2'd0;
    localparam logic [1:0] ST_MISS   = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    localparam logic KIND_ANSWER = 1'b0;
    localparam logic KIND_EVICT  = 1'b1;

    localparam logic [BYTES_W-1:0] MAX_BYTES_RESET = 48'd1073741824;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_UPDATE,
        S_ANSWER,
        S_CHECK,
        S_EVICT
    } ctl_state_t;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic update;
        logic answer;
        logic evict;
        logic last;
    } dp_cmd_t;

    typedef struct packed {
        logic over_budget;
        logic any_valid;
        logic batch_end;
        logic evict_more;
    } dp_status_t;

endpackage

### rtl/bblru_ctrl.sv
// ----------------------------------------------------------------------------
// bblru_ctrl
// Sequencer: lookup, update, answer, then the purge walk on a batch end over budget.
// ----------------------------------------------------------------------------
module bblru_ctrl
    import bblru_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  dp_status_t stat,
    output dp_cmd_t    cmd
);

    ctl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_ANSWER;
            end
            S_ANSWER:
            begin
                // answer is final unless the purge will evict
                cmd.answer = 1'b1;
                cmd.last   = !(stat.batch_end && stat.over_budget && stat.any_valid);
                state_next = cmd.last ? S_IDLE : S_CHECK;
            end
            S_CHECK:
            begin
                // LRU search over the table into the LRU register
                state_next = S_EVICT;
            end
            S_EVICT:
            begin
                // decide on the total and entries left after this removal
                cmd.evict  = 1'b1;
                cmd.last   = 1'b1;
                state_next = S_IDLE;
                if (stat.evict_more)
                begin
                    cmd.last   = 1'b0;
                    state_next = S_CHECK;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/bblru_dp.sv
// ----------------------------------------------------------------------------
// bblru_dp
// Tag table, recency ranks, byte total and result register.
// ----------------------------------------------------------------------------
module bblru_dp
    import bblru_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dp_cmd_t              cmd,
    output dp_status_t           stat,
    input  logic [BYTES_W-1:0]   max_bytes,
    input  logic [15:0]          source_id,
    input  logic [5:0]           key_depth,
    input  logic [31:0]          key_x,
    input  logic [31:0]          key_y,
    input  logic [31:0]          key_z,
    input  logic [23:0]          cell_count,
    input  logic [7:0]           point_bytes,
    input  logic                 batch_end,
    output logic                 result_valid,
    output logic                 result_kind,
    output logic [1:0]           status,
    output logic [4:0]           slot,
    output logic [15:0]          evicted_source,
    output logic [5:0]           evicted_depth,
    output logic [31:0]          evicted_x,
    output logic [31:0]          evicted_y,
    output logic [31:0]          evicted_z,
    output logic [BYTES_W-1:0]   total_after,
    output logic                 last_result
);

    logic [ENTRIES-1:0]   valid_reg;
    logic [15:0]          tsrc_reg [ENTRIES];
    logic [5:0]           tdep_reg [ENTRIES];
    logic [31:0]          tx_reg   [ENTRIES];
    logic [31:0]          ty_reg   [ENTRIES];
    logic [31:0]          tz_reg   [ENTRIES];
    logic [ENTRY_B_W-1:0] bytes_reg [ENTRIES];
    logic [SLOT_W-1:0]    rank_reg [ENTRIES];
    logic [BYTES_W-1:0]   total_reg;
    logic [SLOT_W:0]      cnt_reg;

    // captured request
    logic [15:0]          q_src_reg;
    logic [5:0]           q_dep_reg;
    logic [31:0]          q_x_reg, q_y_reg, q_z_reg;
    logic [23:0]          q_cells_reg;
    logic [7:0]           q_pb_reg;
    logic                 q_last_reg;

    // lookup results
    logic                 hit_reg, free_ok_reg;
    logic [SLOT_W-1:0]    hit_slot_reg, free_slot_reg;
    logic [ENTRY_B_W-1:0] prod_reg;
    logic [1:0]           ans_status_reg;
    logic [SLOT_W-1:0]    ans_slot_reg;
    logic [SLOT_W-1:0]    lru_reg;

    logic                 hit_c, free_c;
    logic [SLOT_W-1:0]    hit_idx_c, free_idx_c, lru_c;
    logic [SLOT_W-1:0]    lru_rank_c;

    // ranks stay dense, so the LRU entry holds rank count-1
    assign lru_rank_c = SLOT_W'(cnt_reg - 1'b1);

    always_comb
    begin
        hit_c = 1'b0; hit_idx_c = '0; free_c = 1'b0; free_idx_c = '0;
        lru_c = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (valid_reg[i])
            begin
                if (!hit_c && tsrc_reg[i] == q_src_reg && tdep_reg[i] == q_dep_reg &&
                    tx_reg[i] == q_x_reg && ty_reg[i] == q_y_reg && tz_reg[i] == q_z_reg)
                begin
                    hit_c = 1'b1;
                    hit_idx_c = SLOT_W'(i);
                end
                if (rank_reg[i] == lru_rank_c)
                    lru_c = lru_c | SLOT_W'(i);
            end
            else if (!free_c)
            begin
                free_c = 1'b1;
                free_idx_c = SLOT_W'(i);
            end
        end
    end

    logic [BYTES_W:0]     sum_c;
    logic [ENTRY_B_W-1:0] ev_bytes_c;
    logic [BYTES_W-1:0]   ev_total_c;
    logic [ENTRIES-1:0]   valid_left_c;
    assign sum_c      = {1'b0, total_reg} + {{(BYTES_W-ENTRY_B_W+1){1'b0}}, prod_reg};
    assign ev_bytes_c = bytes_reg[lru_reg];
    assign ev_total_c = (total_reg >= BYTES_W'(ev_bytes_c))
                      ? total_reg - BYTES_W'(ev_bytes_c) : '0;
    assign valid_left_c = valid_reg & ~({{(ENTRIES-1){1'b0}}, 1'b1} << lru_reg);

    assign stat.over_budget = total_reg > max_bytes;
    assign stat.any_valid   = |valid_reg;
    assign stat.batch_end   = q_last_reg;
    assign stat.evict_more  = (ev_total_c > max_bytes) && (|valid_left_c);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            q_src_reg <= source_id; q_dep_reg <= key_depth;
            q_x_reg <= key_x; q_y_reg <= key_y; q_z_reg <= key_z;
            q_cells_reg <= cell_count; q_pb_reg <= point_bytes;
            q_last_reg <= batch_end;
        end
        if (cmd.lookup)
        begin
            hit_reg <= hit_c; hit_slot_reg <= hit_idx_c;
            free_ok_reg <= free_c; free_slot_reg <= free_idx_c;
            prod_reg <= ENTRY_B_W'(q_cells_reg * q_pb_reg);
        end
        if (cmd.update)
        begin
            if (hit_reg)
            begin
                for (int i = 0; i < ENTRIES; i++)
                    if (valid_reg[i] && rank_reg[i] < rank_reg[hit_slot_reg])
                        rank_reg[i] <= rank_reg[i] + 1'b1;
                rank_reg[hit_slot_reg] <= '0;
                ans_status_reg <= ST_HIT; ans_slot_reg <= hit_slot_reg;
            end
            else if (free_ok_reg)
            begin
                for (int i = 0; i < ENTRIES; i++)
                    if (valid_reg[i])
                        rank_reg[i] <= rank_reg[i] + 1'b1;
                rank_reg[free_slot_reg]  <= '0;
                tsrc_reg[free_slot_reg]  <= q_src_reg;
                tdep_reg[free_slot_reg]  <= q_dep_reg;
                tx_reg[free_slot_reg]    <= q_x_reg;
                ty_reg[free_slot_reg]    <= q_y_reg;
                tz_reg[free_slot_reg]    <= q_z_reg;
                bytes_reg[free_slot_reg] <= prod_reg;
                ans_status_reg <= ST_MISS; ans_slot_reg <= free_slot_reg;
            end
            else
            begin
                ans_status_reg <= ST_REJECT; ans_slot_reg <= '0;
            end
        end
        lru_reg <= lru_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            total_reg    <= '0;
            cnt_reg      <= '0;
            result_valid <= 1'b0;
        end
        else
        begin
            result_valid <= cmd.answer | cmd.evict;
            if (cmd.update && !hit_reg && free_ok_reg)
            begin
                valid_reg[free_slot_reg] <= 1'b1;
                cnt_reg   <= cnt_reg + 1'b1;
                total_reg <= sum_c[BYTES_W] ? '1 : sum_c[BYTES_W-1:0];
            end
            if (cmd.evict)
            begin
                valid_reg[lru_reg] <= 1'b0;
                cnt_reg   <= cnt_reg - 1'b1;
                total_reg <= ev_total_c;
            end
        end
    end

    // result register: fields settle with the strobe
    always_ff @(posedge clk)
    begin
        if (cmd.answer)
        begin
            result_kind <= KIND_ANSWER; status <= ans_status_reg;
            slot <= 5'(ans_slot_reg);
            evicted_source <= '0; evicted_depth <= '0;
            evicted_x <= '0; evicted_y <= '0; evicted_z <= '0;
            total_after <= total_reg; last_result <= cmd.last;
        end
        else if (cmd.evict)
        begin
            result_kind <= KIND_EVICT; status <= ST_HIT;
            slot <= 5'(lru_reg);
            evicted_source <= tsrc_reg[lru_reg]; evicted_depth <= tdep_reg[lru_reg];
            evicted_x <= tx_reg[lru_reg]; evicted_y <= ty_reg[lru_reg];
            evicted_z <= tz_reg[lru_reg];
            total_after <= ev_total_c;
            last_result <= cmd.last;
        end
    end

endmodule

### rtl/byte_budget_lru_cache_directory_top.sv
// ----------------------------------------------------------------------------
// byte_budget_lru_cache_directory_top
// Size-bounded LRU directory of cached chunks with a byte budget.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to issue a request word. The answer follows the
// lookup, update and answer states; then, on a batch end over budget, one
// eviction report follows each pass through the check and evict states (LRU
// search, then removal). Each result is shown for one cycle on done with its
// fields; the receiver cannot stall, so sample every done. busy drops in the
// cycle that shows the last result (last_result = 1), so the next request can
// be taken at the edge that ends it. The budget register max_bytes sits at APB
// address 0 (64-bit data) and may be written only while busy is low.
module byte_budget_lru_cache_directory_top
    import bblru_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [0:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready,
    input  logic         start,
    output logic         busy,
    input  logic [15:0]  source_id,
    input  logic [5:0]   key_depth,
    input  logic [31:0]  key_x,
    input  logic [31:0]  key_y,
    input  logic [31:0]  key_z,
    input  logic [23:0]  cell_count,
    input  logic [7:0]   point_bytes,
    input  logic         batch_end,
    output logic         done,
    output logic         result_kind,
    output logic [1:0]   status,
    output logic [4:0]   slot,
    output logic [15:0]  evicted_source,
    output logic [5:0]   evicted_depth,
    output logic [31:0]  evicted_x,
    output logic [31:0]  evicted_y,
    output logic [31:0]  evicted_z,
    output logic [47:0]  total_after,
    output logic         last_result
);

    logic [BYTES_W-1:0] max_bytes_reg;
    dp_cmd_t    cmd;
    dp_status_t stat;

    assign pready = 1'b1;
    assign prdata = (paddr == 1'b0) ? {16'd0, max_bytes_reg} : 64'd0;

    // budget register: written on the APB access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bytes_reg <= MAX_BYTES_RESET;
        end
        else if (psel && penable && pwrite && paddr == 1'b0)
        begin
            max_bytes_reg <= pwdata[BYTES_W-1:0];
        end
    end

    bblru_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    bblru_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .max_bytes      (max_bytes_reg),
        .source_id      (source_id),
        .key_depth      (key_depth),
        .key_x          (key_x),
        .key_y          (key_y),
        .key_z          (key_z),
        .cell_count     (cell_count),
        .point_bytes    (point_bytes),
        .batch_end      (batch_end),
        .result_valid   (done),
        .result_kind    (result_kind),
        .status         (status),
        .slot           (slot),
        .evicted_source (evicted_source),
        .evicted_depth  (evicted_depth),
        .evicted_x      (evicted_x),
        .evicted_y      (evicted_y),
        .evicted_z      (evicted_z),
        .total_after    (total_after),
        .last_result    (last_result)
    );

endmodule

### rtl/bblru_checker.sv
// ----------------------------------------------------------------------------
// bblru_sva
// Port-level checks on the request and result sequence.
// ----------------------------------------------------------------------------
module bblru_sva
    import bblru_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic       result_kind,
    input logic [1:0] status,
    input logic       last_result
);

    // an accepted request raises busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("busy not raised");

    // busy is low in the cycle that shows the final result
    a_drop: assert property (@(posedge clk) disable iff (!rst_n)
        done && last_result |-> !busy) else $error("busy held after last");

    // no result while idle
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy)) else $error("result while idle");

    // eviction reports carry a zero status
    a_evst: assert property (@(posedge clk) disable iff (!rst_n)
        done && result_kind == KIND_EVICT |-> status == ST_HIT)
        else $error("eviction status");

endmodule

bind byte_budget_lru_cache_directory_top bblru_sva u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .result_kind (result_kind),
    .status      (status),
    .last_result (last_result)
);

### dv/bblru_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bblru_checker
// Watches the request, result and APB channels of the chunk directory, keeps
// its own copy of the directory and budget, and compares every result word.
// ----------------------------------------------------------------------------
module bblru_checker
    import bblru_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [63:0] pwdata,
    input  logic [63:0] prdata,
    input  logic        pready,
    input  logic        start,
    input  logic        busy,
    input  logic [15:0] source_id,
    input  logic [5:0]  key_depth,
    input  logic [31:0] key_x,
    input  logic [31:0] key_y,
    input  logic [31:0] key_z,
    input  logic [23:0] cell_count,
    input  logic [7:0]  point_bytes,
    input  logic        batch_end,
    input  logic        done,
    input  logic        result_kind,
    input  logic [1:0]  status,
    input  logic [4:0]  slot,
    input  logic [15:0] evicted_source,
    input  logic [5:0]  evicted_depth,
    input  logic [31:0] evicted_x,
    input  logic [31:0] evicted_y,
    input  logic [31:0] evicted_z,
    input  logic [47:0] total_after,
    input  logic        last_result,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic        kind;
        logic [1:0]  status;
        logic [4:0]  slot;
        logic [15:0] src;
        logic [5:0]  dep;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [47:0] total;
        logic        last;
    } dir_word_t;

    localparam logic [47:0] SAT48 = 48'hFFFF_FFFF_FFFF;

    logic [47:0]  budget;
    logic         live [ENTRIES];
    logic [15:0]  t_src [ENTRIES];
    logic [5:0]   t_dep [ENTRIES];
    logic [31:0]  t_x [ENTRIES];
    logic [31:0]  t_y [ENTRIES];
    logic [31:0]  t_z [ENTRIES];
    logic [31:0]  sz [ENTRIES];
    int           age [ENTRIES];
    logic [47:0]  cached;
    dir_word_t    expected_words [$];

    assign pending = expected_words.size();

    function automatic dir_word_t mk(logic k, logic [1:0] st, int s, int e);
        dir_word_t w;
        w = '0;
        w.kind = k;
        w.status = st;
        w.slot = s[4:0];
        if (e >= 0)
        begin
            w.src = t_src[e];
            w.dep = t_dep[e];
            w.x = t_x[e];
            w.y = t_y[e];
            w.z = t_z[e];
        end
        w.total = cached;
        return w;
    endfunction

    // Update the directory for one request and queue the words it causes.
    task automatic lookup_and_purge();
        int        hit;
        int        free_slot;
        int        old;
        int        lru;
        logic [63:0] sum;
        logic [31:0] b;
        hit = -1;
        free_slot = -1;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (live[i])
            begin
                if (hit < 0 && t_src[i] == source_id && t_dep[i] == key_depth &&
                    t_x[i] == key_x && t_y[i] == key_y && t_z[i] == key_z)
                    hit = i;
            end
            else if (free_slot < 0)
                free_slot = i;
        end
        if (hit >= 0)
        begin
            old = age[hit];
            for (int i = 0; i < ENTRIES; i++)
                if (live[i] && age[i] < old)
                    age[i]++;
            age[hit] = 0;
            expected_words.insert(expected_words.size(), mk(KIND_ANSWER, ST_HIT, hit, -1));
        end
        else if (free_slot >= 0)
        begin
            b = cell_count * point_bytes;
            for (int i = 0; i < ENTRIES; i++)
                if (live[i])
                    age[i]++;
            live[free_slot] = 1'b1;
            t_src[free_slot] = source_id;
            t_dep[free_slot] = key_depth;
            t_x[free_slot] = key_x;
            t_y[free_slot] = key_y;
            t_z[free_slot] = key_z;
            sz[free_slot] = b;
            age[free_slot] = 0;
            sum = {16'd0, cached} + {32'd0, b};
            cached = (sum > {16'd0, SAT48}) ? SAT48 : sum[47:0];
            expected_words.insert(expected_words.size(),
                                  mk(KIND_ANSWER, ST_MISS, free_slot, -1));
        end
        else
            expected_words.insert(expected_words.size(), mk(KIND_ANSWER, ST_REJECT, 0, -1));
        if (batch_end)
        begin
            while (cached > budget)
            begin
                lru = -1;
                for (int i = 0; i < ENTRIES; i++)
                    if (live[i] && (lru < 0 || age[i] > age[lru]))
                        lru = i;
                if (lru < 0)
                    break;
                live[lru] = 1'b0;
                cached = (cached >= {16'd0, sz[lru]}) ? cached - {16'd0, sz[lru]} : '0;
                expected_words.insert(expected_words.size(), mk(KIND_EVICT, ST_HIT, lru, lru));
            end
        end
        expected_words[expected_words.size() - 1].last = 1'b1;
    endtask

    task automatic report(string name, logic [63:0] e, logic [63:0] a);
        if (e !== a)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        dir_word_t w;
        if (!rst_n)
        begin
            budget = MAX_BYTES_RESET;
            cached = '0;
            for (int i = 0; i < ENTRIES; i++)
                live[i] = 1'b0;
            expected_words.delete();
            fail_count = 0;
        end
        else
        begin
            if (psel && penable && pready)
            begin
                if (pwrite)
                    budget = pwdata[47:0];
                else
                    report("prdata", {16'd0, budget}, prdata);
            end
            if (start && !busy)
                lookup_and_purge();
            if (done)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, actual kind %0b slot %0d",
                             $time, result_kind, slot);
                    fail_count++;
                end
                else
                begin
                    w = expected_words.pop_front();
                    report("result_kind", 64'(w.kind), 64'(result_kind));
                    report("status", 64'(w.status), 64'(status));
                    report("slot", 64'(w.slot), 64'(slot));
                    report("evicted_source", 64'(w.src), 64'(evicted_source));
                    report("evicted_depth", 64'(w.dep), 64'(evicted_depth));
                    report("evicted_x", 64'(w.x), 64'(evicted_x));
                    report("evicted_y", 64'(w.y), 64'(evicted_y));
                    report("evicted_z", 64'(w.z), 64'(evicted_z));
                    report("total_after", 64'(w.total), 64'(total_after));
                    report("last_result", 64'(w.last), 64'(last_result));
                end
            end
        end
    end

endmodule

### dv/tb_byte_budget_lru_cache_directory_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_byte_budget_lru_cache_directory_top
// Drives chunk requests and budget writes into the LRU directory; the checker
// beside the block predicts and compares every answer and eviction word.
// ----------------------------------------------------------------------------
module tb_byte_budget_lru_cache_directory_top
    import bblru_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int POOL = 48;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [0:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        start = 1'b0;
    logic        busy;
    logic [15:0] source_id = '0;
    logic [5:0]  key_depth = '0;
    logic [31:0] key_x = '0;
    logic [31:0] key_y = '0;
    logic [31:0] key_z = '0;
    logic [23:0] cell_count = '0;
    logic [7:0]  point_bytes = 8'd1;
    logic        batch_end = 1'b0;
    logic        done;
    logic        result_kind;
    logic [1:0]  status;
    logic [4:0]  slot;
    logic [15:0] evicted_source;
    logic [5:0]  evicted_depth;
    logic [31:0] evicted_x;
    logic [31:0] evicted_y;
    logic [31:0] evicted_z;
    logic [47:0] total_after;
    logic        last_result;
    int          fail_count;
    int          pending;
    int          quiet_cycles = 0;

    // Pool of recently used keys so that random traffic hits often.
    logic [15:0] pool_src [POOL];
    logic [5:0]  pool_dep [POOL];
    logic [31:0] pool_x [POOL];
    logic [31:0] pool_y [POOL];
    logic [31:0] pool_z [POOL];

    always #5 clk = ~clk;

    byte_budget_lru_cache_directory_top dut (.*);

    bblru_checker chk (.*);

    // Watchdog: count cycles where no handshake of any kind completes.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Issue one request word; hold start until the block takes it.
    task automatic send_word(logic [15:0] s, logic [5:0] d, logic [31:0] x,
                             logic [31:0] y, logic [31:0] z, logic [23:0] c,
                             logic [7:0] p, logic e);
        forever
        begin
            @(negedge clk);
            if (!busy)
                break;
            start <= 1'b0;
        end
        start <= 1'b1;
        source_id <= s;
        key_depth <= d;
        key_x <= x;
        key_y <= y;
        key_z <= z;
        cell_count <= c;
        point_bytes <= p;
        batch_end <= e;
        @(posedge clk);
    endtask

    task automatic hold_off(int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // Drain every outstanding word, then give the block time to settle.
    task automatic drain();
        hold_off(1);
        while (pending != 0 || busy)
            @(negedge clk);
        hold_off(12);
    endtask

    // Write the budget over APB, then read it back for the checker.
    task automatic set_budget(logic [47:0] v);
        drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= '0;
        pwdata <= {16'd0, v};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic random_phase(logic [47:0] budget_val, int n_items);
        int          k;
        int          burst;
        logic [15:0] s;
        logic [5:0]  d;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [23:0] c;
        logic [7:0]  p;
        set_budget(budget_val);
        burst = 0;
        for (int n = 0; n < n_items; n++)
        begin
            k = $urandom_range(0, POOL - 1);
            if ($urandom_range(0, 9) < 4)
            begin
                // Fresh key: replace a pool slot with fully random content.
                pool_src[k] = 16'($urandom);
                pool_dep[k] = 6'($urandom);
                pool_x[k] = $urandom;
                pool_y[k] = $urandom;
                pool_z[k] = $urandom;
            end
            s = pool_src[k];
            d = pool_dep[k];
            x = pool_x[k];
            y = pool_y[k];
            z = pool_z[k];
            case ($urandom_range(0, 9))
                0: c = 24'($urandom);
                1, 2, 3: c = 24'($urandom_range(0, 1 << 20));
                default: c = 24'($urandom_range(0, 4095));
            endcase
            p = ($urandom_range(0, 7) == 0) ? 8'd255 : 8'($urandom_range(1, 255));
            send_word(s, d, x, y, z, c, p, $urandom_range(0, 3) == 0);
            // Sender bursts with random gaps between them.
            if (burst == 0)
            begin
                burst = $urandom_range(1, 12);
                if ($urandom_range(0, 3) != 0)
                    hold_off($urandom_range(1, 6));
            end
            else
                burst--;
            // Pause until everything expected has arrived, once per phase.
            if (n == n_items / 2)
                drain();
        end
    endtask

    initial
    begin
        for (int i = 0; i < POOL; i++)
        begin
            pool_src[i] = 16'($urandom);
            pool_dep[i] = 6'($urandom);
            pool_x[i] = $urandom;
            pool_y[i] = $urandom;
            pool_z[i] = $urandom;
        end
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        hold_off(2);

        // Directed: extremes of key and size under the reset budget.
        send_word('0, '0, '0, '0, '0, '0, 8'd1, 1'b0);
        send_word('1, '1, '1, '1, '1, '1, 8'd255, 1'b1);
        send_word('0, '0, '0, '0, '0, 24'd5, 8'd7, 1'b0);
        send_word(16'h00FF, 6'd21, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F,
                  24'd0, 8'd1, 1'b0);
        send_word('1, '1, '1, '1, '1, '1, 8'd255, 1'b1);
        send_word(16'hFF00, 6'd42, 32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_F0F0,
                  24'd100, 8'd128, 1'b1);

        // Zero budget: purge takes everything, the fresh entry included.
        set_budget('0);
        send_word(16'd1, 6'd1, 32'd1, 32'd1, 32'd1, 24'd10, 8'd2, 1'b0);
        send_word(16'd2, 6'd2, 32'd2, 32'd2, 32'd2, 24'd10, 8'd2, 1'b0);
        send_word(16'd1, 6'd1, 32'd1, 32'd1, 32'd1, 24'd10, 8'd2, 1'b0);
        send_word(16'd3, 6'd3, 32'd3, 32'd3, 32'd3, 24'd1, 8'd1, 1'b1);
        send_word(16'd4, 6'd4, 32'd4, 32'd4, 32'd4, 24'd0, 8'd9, 1'b1);

        // Random phases over a spread of budgets, widest first to fill the table.
        random_phase(48'hFFFF_FFFF_FFFF, 70);
        random_phase(48'd1 << 30, 70);
        random_phase(48'd1 << 24, 70);
        random_phase({16'd0, $urandom}, 70);
        random_phase(MAX_BYTES_RESET, 70);

        drain();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
